// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the digitizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FND_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define FND_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- design/fnd_pkg.sv -----
// ---------------------------------------------------------------------------
// fnd_pkg
// Shared types and codes of the FASTA nucleotide digitizer.
// ---------------------------------------------------------------------------
`default_nettype none

package fnd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 2;

  localparam logic KIND_BASE   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic             emit;
    logic             kind;
    logic [CodeW-1:0] code;
    logic             unk;
  } fnd_result_t;

endpackage

`default_nettype wire

// ----- design/fnd_stream_if.sv -----
// ---------------------------------------------------------------------------
// fnd_in_if / fnd_out_if
// Valid/ready channels carrying text bytes in and digitized results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface fnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface fnd_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] base_code;
  logic       is_unknown;

  modport source (output valid, output result_kind, output base_code,
                  output is_unknown, input ready);
  modport sink (input valid, input result_kind, input base_code,
                input is_unknown, output ready);
endinterface

`default_nettype wire

// ----- design/fasta_nucleotide_digitizer_top.sv -----
// ---------------------------------------------------------------------------
// fasta_nucleotide_digitizer_top
// Turns a FASTA byte stream into 2-bit base codes and record markers.
// ---------------------------------------------------------------------------
// Usage:
//   Bytes of the text stream enter on in_ch, one per transaction. Each
//   sequence byte other than newline yields one transaction on out_ch with a
//   2-bit code (A, C, G, T in either case) or the unknown flag. A '>' at the
//   start of a line yields one record marker; the rest of that header line,
//   newlines, and all lines before the first header yield nothing.
//   A byte is captured in an input register and decoded from there into
//   the result register, which presents it on out_ch. The two register
//   stages sustain one byte per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its result and the
//   input register holds the next byte; in_ch.ready drops once both are full.
//   A synchronous reset empties both stages and returns the parser to the
//   state before the first header, with the next byte taken as a line start.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fasta_nucleotide_digitizer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  fnd_in_if.sink    in_ch,
  fnd_out_if.source out_ch
);
  import fnd_pkg::*;

  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r;
  logic [CodeW-1:0] out_code_r;
  logic             out_unk_r;
  logic             out_free, s1_step;
  fnd_result_t      res;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_step     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  fnd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_step),
    .byte_in (s1_byte_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.in_byte;
    end
    if (s1_step && res.emit) begin
      out_kind_r <= res.kind;
      out_code_r <= res.code;
      out_unk_r  <= res.unk;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.base_code   = out_code_r;
  assign out_ch.is_unknown  = out_unk_r;

  `FND_ASSERT_IMP(a_marker_clean, clk, rst_n,
                  out_valid_r && (out_kind_r == KIND_RECORD),
                  (out_code_r == '0) && !out_unk_r)
  `FND_ASSERT_IMP(a_unknown_code_zero, clk, rst_n,
                  out_valid_r && out_unk_r, out_code_r == '0)
  `FND_ASSERT_NEXT(a_s1_holds_on_stall, clk, rst_n,
                   s1_valid_r && !out_free, s1_valid_r && $stable(s1_byte_r))

endmodule

`default_nettype wire

// ----- design/fnd_parser.sv -----
// ---------------------------------------------------------------------------
// fnd_parser
// Line and record state of the FASTA stream with the per-byte decode.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fnd_parser (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [fnd_pkg::ByteW-1:0] byte_in,
  output fnd_pkg::fnd_result_t          res
);
  import fnd_pkg::*;

  typedef enum logic [2:0] {
    MODE_SKIP   = 3'b001,
    MODE_HEADER = 3'b010,
    MODE_SEQ    = 3'b100
  } mode_t;

  localparam logic [ByteW-1:0] CH_GT = 8'h3E;
  localparam logic [ByteW-1:0] CH_NL = 8'h0A;
  localparam logic [ByteW-1:0] CH_A  = 8'h41;
  localparam logic [ByteW-1:0] CH_C  = 8'h43;
  localparam logic [ByteW-1:0] CH_G  = 8'h47;
  localparam logic [ByteW-1:0] CH_T  = 8'h54;
  localparam logic [ByteW-1:0] CH_LA = 8'h61;
  localparam logic [ByteW-1:0] CH_LZ = 8'h7A;

  localparam logic [CodeW-1:0] BASE_A = 2'd0;
  localparam logic [CodeW-1:0] BASE_C = 2'd1;
  localparam logic [CodeW-1:0] BASE_G = 2'd2;
  localparam logic [CodeW-1:0] BASE_T = 2'd3;

  mode_t            mode_r, mode_nxt;
  logic             line_start_r, line_start_nxt;
  logic             is_nl, opens_record;
  logic [ByteW-1:0] upper;

  assign is_nl        = (byte_in == CH_NL);
  assign opens_record = line_start_r && (byte_in == CH_GT) && (mode_r != MODE_HEADER);
  assign upper        = ((byte_in >= CH_LA) && (byte_in <= CH_LZ)) ?
                        (byte_in & 8'hDF) : byte_in;

  always_comb begin
    res = '0;
    if (!is_nl) begin
      if (opens_record) begin
        res.emit = 1'b1;
        res.kind = KIND_RECORD;
      end else if (mode_r == MODE_SEQ) begin
        res.emit = 1'b1;
        res.kind = KIND_BASE;
        case (upper)
          CH_A:    res.code = BASE_A;
          CH_C:    res.code = BASE_C;
          CH_G:    res.code = BASE_G;
          CH_T:    res.code = BASE_T;
          default: res.unk  = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    line_start_nxt = line_start_r;
    if (step) begin
      line_start_nxt = is_nl;
      unique case (mode_r)
        MODE_HEADER: if (is_nl) mode_nxt = MODE_SEQ;
        MODE_SEQ:    if (opens_record) mode_nxt = MODE_HEADER;
        default:     if (opens_record) mode_nxt = MODE_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SKIP;
      line_start_r <= 1'b1;
    end else begin
      mode_r       <= mode_nxt;
      line_start_r <= line_start_nxt;
    end
  end

  `FND_ASSERT_NEXT(a_nl_sets_start, clk, rst_n, step && is_nl, line_start_r)
  `FND_ASSERT_NEXT(a_marker_enters_header, clk, rst_n,
                   step && res.emit && (res.kind == KIND_RECORD),
                   (mode_r == MODE_HEADER) && !line_start_r)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the FASTA nucleotide digitizer.
// ---------------------------------------------------------------------------
// The bench feeds a byte stream into the digitizer. It starts with a short
// hand-built prologue covering skipped lines, headers, both letter cases and
// odd bytes. Random FASTA records follow, mixed with noise. A parser model
// inside the scoreboard predicts every marker and base code, and each output
// transaction is checked in order. The output side stalls at random and once
// for a long stretch, which makes the block back up its input.
// ---------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fnd_pkg::*;

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;

  localparam logic [CodeW-1:0] CODE_A = 2'd0;
  localparam logic [CodeW-1:0] CODE_C = 2'd1;
  localparam logic [CodeW-1:0] CODE_G = 2'd2;
  localparam logic [CodeW-1:0] CODE_T = 2'd3;

  localparam int PHASE_BYTES = 533;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {
    PM_PRELUDE = 2'd0,
    PM_HEADER  = 2'd1,
    PM_BASES   = 2'd2,
    PM_SPARE   = 2'd3
  } parse_mode_t;

  typedef struct packed {
    logic             kind;
    logic [CodeW-1:0] code;
    logic             unk;
  } base_result_t;

  class fasta_code_tracker;
    parse_mode_t  mode;
    logic         line_start;
    base_result_t expected_codes[$];
    int           errors;
    int           bytes_seen;
    int           markers;
    int           bases;
    int           unknowns;

    function new();
      mode       = PM_PRELUDE;
      line_start = 1'b1;
      errors     = 0;
      bytes_seen = 0;
      markers    = 0;
      bases      = 0;
      unknowns   = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      logic         first;
      logic [7:0]   up;
      base_result_t r;
      first = line_start;
      bytes_seen++;
      if (b == CH_NL) begin
        line_start = 1'b1;
        if (mode == PM_HEADER) mode = PM_BASES;
        return;
      end
      line_start = 1'b0;
      if (first && b == CH_GT && mode != PM_HEADER) begin
        mode   = PM_HEADER;
        r.kind = KIND_RECORD;
        r.code = CODE_A;
        r.unk  = 1'b0;
        expected_codes = {expected_codes, r};
        markers++;
        return;
      end
      if (mode != PM_BASES) return;
      up     = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
      r.kind = KIND_BASE;
      r.code = CODE_A;
      r.unk  = 1'b0;
      case (up)
        CH_A: r.code = CODE_A;
        CH_C: r.code = CODE_C;
        CH_G: r.code = CODE_G;
        CH_T: r.code = CODE_T;
        default: r.unk = 1'b1;
      endcase
      if (r.unk) unknowns++;
      else bases++;
      expected_codes = {expected_codes, r};
    endfunction

    function void match_result(base_result_t got);
      base_result_t want;
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected result kind=%0h code=%0h unk=%0h",
                 $time, got.kind, got.code, got.unk);
        errors++;
        return;
      end
      want = expected_codes.pop_front();
      if (got.kind !== want.kind || got.code !== want.code || got.unk !== want.unk) begin
        $display("%0t: mismatch expected kind=%0h code=%0h unk=%0h,",
                 $time, want.kind, want.code, want.unk,
                 " actual kind=%0h code=%0h unk=%0h",
                 got.kind, got.code, got.unk);
        errors++;
      end
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fnd_in_if  in_if();
  fnd_out_if out_if();

  fasta_nucleotide_digitizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  fasta_code_tracker tracker = new();

  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  logic [7:0] stream[$];

  logic [7:0] prologue [24] = '{
    8'h78, CH_GT, 8'h61, CH_NL,
    CH_GT, 8'h68, CH_GT, CH_NL,
    8'h61, CH_C, 8'h67, CH_T,
    CH_GT, CH_CR, 8'h20, 8'h09, 8'hFF, 8'h00, CH_NL,
    CH_GT, CH_NL, CH_GT, 8'h80, CH_NL
  };

  logic [7:0] letters [8] = '{CH_A, CH_C, CH_G, CH_T, 8'h61, 8'h63, 8'h67, 8'h74};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_NL);
    return b;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stream = {stream, b};
  endfunction

  function automatic void add_record();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
    end else if (pick < 12) begin
      add_byte(CH_GT);
      repeat ($urandom_range(0, 10)) add_byte(letters[$urandom_range(7)]);
      add_byte(CH_NL);
    end else begin
      add_byte(CH_GT);
      repeat ($urandom_range(0, 8)) add_byte(text_byte());
      add_byte(CH_NL);
      repeat ($urandom_range(0, 4)) begin
        repeat ($urandom_range(0, 16)) begin
          if ($urandom_range(99) < 85) add_byte(letters[$urandom_range(7)]);
          else add_byte(text_byte());
        end
        if ($urandom_range(9) == 0) add_byte(CH_CR);
        add_byte(CH_NL);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do begin
      @(negedge clk);
      took = in_if.ready;
      @(posedge clk);
    end while (took !== 1'b1);
    tracker.take_byte(b);
  endtask

  initial begin : ready_driver
    int  hold_left;
    logic hold_done;
    hold_left      = 0;
    hold_done      = 1'b0;
    out_if.ready  <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        hold_left     = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : result_monitor
    logic         take;
    base_result_t got;
    forever begin
      @(negedge clk);
      take     = rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1;
      got.kind = out_if.result_kind;
      got.code = out_if.base_code;
      got.unk  = out_if.is_unknown;
      @(posedge clk);
      if (take) tracker.match_result(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    send_idle_pct  = 34;
    recv_idle_pct  = 65;
    hold_req       = 1'b0;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (prologue[i]) send_byte(prologue[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; hold_req = 1'b1; end
      endcase
      stream.delete();
      while (stream.size() < PHASE_BYTES) add_record();
      foreach (stream[i]) send_byte(stream[i]);
    end

    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes; checked %0d record markers, %0d bases and %0d unknown bytes.",
             tracker.bytes_seen, tracker.markers, tracker.bases, tracker.unknowns);
    $display("Runs covered sender and receiver gaps, back-to-back traffic",
             " and one long output stall.");
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
